// File: hdl/assert_macros.svh
// Assertion helpers; every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NumRoundsDef = 10;
    localparam int BlockW       = 128;

    // Key register indexes on the configuration port
    localparam logic CfgKeyLow  = 1'b0;
    localparam logic CfgKeyHigh = 1'b1;

    // Control for one pass of the round datapath
    typedef struct packed {
        logic op;     // 1: inverse cipher
        logic first;  // key addition only
        logic last;   // no column mixing
    } t_round_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] rcon(input logic [7:0] rd);
        logic [7:0] r;
        unique case (rd)
            8'd1:    r = 8'h01;
            8'd2:    r = 8'h02;
            8'd3:    r = 8'h04;
            8'd4:    r = 8'h08;
            8'd5:    r = 8'h10;
            8'd6:    r = 8'h20;
            8'd7:    r = 8'h40;
            8'd8:    r = 8'h80;
            8'd9:    r = 8'h1b;
            8'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Next round-key row from the previous one
    function automatic logic [BlockW-1:0] next_round_key(input logic [BlockW-1:0] p,
                                                         input logic [7:0] rd);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {p[103:96], p[127:104]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
        t[7:0] = t[7:0] ^ rcon(rd);
        w0 = p[31:0] ^ t;
        w1 = p[63:32] ^ w0;
        w2 = p[95:64] ^ w1;
        w3 = p[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

endpackage

// File: hdl/aes_ram.sv
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/aes_round.sv
`timescale 1ns / 1ps
module aes_round (
    input  logic [aes_pkg::BlockW-1:0] i_state,
    input  logic [aes_pkg::BlockW-1:0] i_key,
    input  aes_pkg::t_round_ctl        i_ctl,
    output logic [aes_pkg::BlockW-1:0] o_state
);

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[7:0]; a1 = c[15:8]; a2 = c[23:16]; a3 = c[31:24];
        return {xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2,
                xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1,
                xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0,
                xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int j = 0; j < 4; j++) begin
            a[j]  = c[8*j +: 8];
            x2[j] = xt(a[j]);
            x4[j] = xt(x2[j]);
            x8[j] = xt(x4[j]);
            m9[j] = x8[j] ^ a[j];
            mb[j] = x8[j] ^ x2[j] ^ a[j];
            md[j] = x8[j] ^ x4[j] ^ a[j];
            me[j] = x8[j] ^ x4[j] ^ x2[j];
        end
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = me[k] ^ mb[(k+1)%4] ^ md[(k+2)%4] ^ m9[(k+3)%4];
        end
        return r;
    endfunction

    logic [aes_pkg::BlockW-1:0] w_fwd;
    logic [aes_pkg::BlockW-1:0] w_fwd_mix;
    logic [aes_pkg::BlockW-1:0] w_inv;
    logic [aes_pkg::BlockW-1:0] w_inv_key;
    logic [aes_pkg::BlockW-1:0] w_inv_mix;

    // Substitute and shift rows, both directions
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_fwd[8*(4*c+r) +: 8] = aes_pkg::SBOX[i_state[8*(4*((c+r)%4)+r) +: 8]];
                w_inv[8*(4*c+r) +: 8] =
                    aes_pkg::INV_SBOX[i_state[8*(4*((c+4-r)%4)+r) +: 8]];
            end
        end
    end

    // Mix columns
    always_comb begin
        w_inv_key = w_inv ^ i_key;
        for (int c = 0; c < 4; c++) begin
            w_fwd_mix[32*c +: 32] = mix_col(w_fwd[32*c +: 32]);
            w_inv_mix[32*c +: 32] = inv_mix_col(w_inv_key[32*c +: 32]);
        end
    end

    // Pick the step result
    always_comb begin
        if (i_ctl.first) begin
            o_state = i_state ^ i_key;
        end else if (!i_ctl.op) begin
            o_state = (i_ctl.last ? w_fwd : w_fwd_mix) ^ i_key;
        end else begin
            o_state = i_ctl.last ? w_inv_key : w_inv_mix;
        end
    end

endmodule

// File: hdl/aes128_block_cipher.sv
`timescale 1ns / 1ps
// Channel  | handshake               | payload
// input    | i_in_valid / o_in_stall | i_op, i_block_low, i_block_high
// output   | o_out_valid / i_out_stall | o_result_low, o_result_high
// config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
// An item passes accept, round-key fetch, one round step per key row over the
// key memory read port, and result transfer.
// The first item after reset or a key write is preceded by key expansion,
// one round-key row written per cycle.
// Reset is synchronous and clears the control state; a waiting result holds
// under i_out_stall while the next item may already be accepted.
module aes128_block_cipher #(
    parameter int NUM_ROUNDS = aes_pkg::NumRoundsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high
);

    `include "assert_macros.svh"

    localparam int Rows = NUM_ROUNDS + 1;
    localparam int RW   = $clog2(Rows);
    localparam logic [RW-1:0] LastStep = RW'(NUM_ROUNDS);

    localparam logic CFG_KEY_LOW  = aes_pkg::CfgKeyLow;
    localparam logic CFG_KEY_HIGH = aes_pkg::CfgKeyHigh;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPAND = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_ROUND  = 5'b01000,
        ST_FLUSH  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_cnt, n_cnt;
    logic r_op;
    logic r_keys_ready;
    logic r_out_valid;
    logic [63:0] r_key_low, r_key_high;
    logic [aes_pkg::BlockW-1:0] r_data, n_data;
    logic [aes_pkg::BlockW-1:0] r_prev;
    logic [aes_pkg::BlockW-1:0] r_res;

    logic                       w_accept;
    logic                       w_we;
    logic [aes_pkg::BlockW-1:0] w_wdata;
    logic [RW-1:0]              w_step;
    logic [RW-1:0]              w_raddr;
    logic [aes_pkg::BlockW-1:0] w_rkey;
    logic [aes_pkg::BlockW-1:0] w_round;
    logic                       w_out_free;
    aes_pkg::t_round_ctl        w_ctl;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Expand one round-key row per cycle
    assign w_we    = (r_state == ST_EXPAND);
    assign w_wdata = (r_cnt == '0) ? {r_key_high, r_key_low}
                                   : aes_pkg::next_round_key(r_prev, 8'(r_cnt));

    // Fetch the key row for the next step
    always_comb begin
        if (r_state == ST_FETCH) begin
            w_step = '0;
        end else if (r_cnt == LastStep) begin
            w_step = r_cnt;
        end else begin
            w_step = r_cnt + 1'b1;
        end
        w_raddr = r_op ? LastStep - w_step : w_step;
    end

    aes_ram #(
        .WIDTH(aes_pkg::BlockW),
        .DEPTH(Rows)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rkey)
    );

    assign w_ctl.op    = r_op;
    assign w_ctl.first = (r_cnt == '0);
    assign w_ctl.last  = (r_cnt == LastStep);

    aes_round u_round (
        .i_state(r_data),
        .i_key  (w_rkey),
        .i_ctl  (w_ctl),
        .o_state(w_round)
    );

    // Sequence accept, expansion and rounds
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_data  = r_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_data  = {i_block_high, i_block_low};
                    n_cnt   = '0;
                    n_state = r_keys_ready ? ST_FETCH : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (r_cnt == LastStep) begin
                    n_cnt   = '0;
                    n_state = ST_FETCH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FETCH: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_data = w_round;
                if (r_cnt == LastStep) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_FLUSH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_keys_ready <= 1'b0;
                unique case (i_cfg_index)
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_state == ST_EXPAND && r_cnt == LastStep) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (w_accept) begin
            r_op <= i_op;
        end
        if (w_we) begin
            r_prev <= w_wdata;
        end
        if (r_state == ST_FLUSH && w_out_free) begin
            r_res <= r_data;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_low  = r_res[63:0];
    assign o_result_high = r_res[127:64];

    `AST_IMPL(a_round_keys_ready, r_state == ST_ROUND, r_keys_ready)
    `AST_IMPL(a_write_only_expand, w_we, r_state == ST_EXPAND)
    `AST_NEXT(a_flush_delivers, r_state == ST_FLUSH && w_out_free, r_out_valid)
    `AST_NEXT(a_cfg_clears_ready, i_cfg_we, !r_keys_ready)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

    typedef enum logic {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} t_cipher_op;
    localparam logic REG_KEY_LOW  = aes_pkg::CfgKeyLow;
    localparam logic REG_KEY_HIGH = aes_pkg::CfgKeyHigh;
    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   SETTLE       = 40;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = 1'b0;
    logic [63:0] i_block_low = '0;
    logic [63:0] i_block_high = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_result_low;
    logic [63:0] o_result_high;

    aes128_block_cipher dut (.*);

    // Predictor state
    logic [7:0]  fwd_tab [256];
    logic [7:0]  inv_tab [256];
    logic [63:0] key_lo_q = '0;
    logic [63:0] key_hi_q = '0;
    logic [31:0] sched [44];
    t_block      cipher_results [$];

    int err_count = 0;
    int cycles = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    int hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = xtime(x);
        end
        return acc;
    endfunction

    // Build substitution tables from field inverse and affine map
    task automatic build_sbox();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = 8'(x);
        end
    endtask

    // Expand the held key into the 44-word schedule
    task automatic expand_schedule();
        logic [127:0] k;
        logic [31:0]  t;
        logic [7:0]   rc;
        k = {key_hi_q, key_lo_q};
        rc = 8'h01;
        for (int i = 0; i < 4; i++) sched[i] = k[32*i +: 32];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[7:0], t[31:8]};
                for (int b = 0; b < 4; b++) t[8*b +: 8] = fwd_tab[t[8*b +: 8]];
                t[7:0] ^= rc;
                rc = xtime(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    function automatic logic [127:0] add_round_key(logic [127:0] v, int rd);
        for (int c = 0; c < 4; c++) v[32*c +: 32] ^= sched[4*rd + c];
        return v;
    endfunction

    function automatic logic [127:0] sub_bytes(logic [127:0] v, logic inv);
        for (int k = 0; k < 16; k++)
            v[8*k +: 8] = inv ? inv_tab[v[8*k +: 8]] : fwd_tab[v[8*k +: 8]];
        return v;
    endfunction

    function automatic logic [127:0] shift_rows(logic [127:0] v, logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
                t[8*(4*c + r) +: 8] = v[8*(4*src + r) +: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(logic [127:0] v, logic inv);
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] acc;
        if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = v[8*(4*c + j) +: 8];
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int j = 0; j < 4; j++) acc ^= gmul(a[j], m[(j + 4 - r) % 4]);
                v[8*(4*c + r) +: 8] = acc;
            end
        end
        return v;
    endfunction

    function automatic t_block aes_transform(t_cipher_op op, t_block blk);
        logic [127:0] s;
        s = {blk.hi, blk.lo};
        if (op == OP_ENCRYPT) begin
            s = add_round_key(s, 0);
            for (int rd = 1; rd <= 10; rd++) begin
                s = shift_rows(sub_bytes(s, 1'b0), 1'b0);
                if (rd != 10) s = mix_columns(s, 1'b0);
                s = add_round_key(s, rd);
            end
        end else begin
            s = add_round_key(s, 10);
            for (int rd = 9; rd >= 0; rd--) begin
                s = add_round_key(sub_bytes(shift_rows(s, 1'b1), 1'b1), rd);
                if (rd != 0) s = mix_columns(s, 1'b1);
            end
        end
        return '{lo: s[63:0], hi: s[127:64]};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s at cycle %0d: got %h want %h", what, cycles, got, want);
        err_count++;
    endtask

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive receiver stall: long hold first, else random
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < rcv_pct);
        end
    end

    // Compare each delivered item with the oldest prediction
    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_low, '0);
            end else begin
                want = cipher_results.pop_front();
                if (o_result_low !== want.lo) report_mismatch("result_low", o_result_low, want.lo);
                if (o_result_high !== want.hi)
                    report_mismatch("result_high", o_result_high, want.hi);
            end
        end
    end

    // Send one item; entered and left at a falling edge
    task automatic send_block(t_cipher_op op, logic [63:0] lo, logic [63:0] hi);
        if ($urandom_range(99) < snd_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_op = op;
        i_block_low = lo;
        i_block_high = hi;
        i_in_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        cipher_results.push_back(aes_transform(op, '{lo: lo, hi: hi}));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (cipher_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write one key register; block is idle here
    task automatic write_key(logic idx, logic [63:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_KEY_LOW) key_lo_q = val;
        else key_hi_q = val;
        expand_schedule();
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_block(t_cipher_op'($urandom_range(1)), {$urandom, $urandom},
                       {$urandom, $urandom});
    endtask

    // Zero key from reset, no write yet
    task automatic test_reset_key();
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '0, '0);
        send_block(OP_ENCRYPT, '1, '1);
    endtask

    // Standard vector and field extremes
    task automatic test_directed();
        t_block kat;
        write_key(REG_KEY_LOW, 64'h0706050403020100);
        write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        kat = aes_transform(OP_ENCRYPT, '{lo: 64'h7766554433221100, hi: 64'hffeeddccbbaa9988});
        if (kat.lo !== 64'h30047b6ad8e0c469) report_mismatch("known low", kat.lo,
                                                            64'h30047b6ad8e0c469);
        if (kat.hi !== 64'h5ac5b47080b7cdd8) report_mismatch("known high", kat.hi,
                                                            64'h5ac5b47080b7cdd8);
        send_block(OP_ENCRYPT, 64'h7766554433221100, 64'hffeeddccbbaa9988);
        send_block(OP_DECRYPT, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8);
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '1, '1);
        send_block(OP_ENCRYPT, {16{4'ha}}, {16{4'h5}});
        send_block(OP_DECRYPT, {16{4'h5}}, {16{4'ha}});
    endtask

    // Key changes between items, one half at a time, extremes included
    task automatic test_key_change();
        write_key(REG_KEY_LOW, '1);
        send_block(OP_ENCRYPT, '0, '1);
        write_key(REG_KEY_HIGH, '1);
        send_block(OP_DECRYPT, '1, '0);
        send_block(OP_ENCRYPT, 64'h1, 64'h8000000000000000);
        write_key(REG_KEY_LOW, '0);
        write_key(REG_KEY_HIGH, '0);
        send_block(OP_ENCRYPT, '1, '1);
    endtask

    // Hold the receiver off so the block backs up, then pause until empty
    task automatic test_back_pressure();
        snd_pct = 0;
        hold_left = 400;
        send_random(20);
        drain();
        send_random(5);
        drain();
    endtask

    // Random keys and items over three idle mixes
    task automatic test_random();
        int pct_snd [3] = '{31, 58, 0};
        int pct_rcv [3] = '{58, 31, 0};
        for (int ph = 0; ph < 3; ph++) begin
            snd_pct = pct_snd[ph];
            rcv_pct = pct_rcv[ph];
            for (int ch = 0; ch < 6; ch++) begin
                if (ch == 0 && ph == 1) begin
                    write_key(REG_KEY_LOW, '1);
                    write_key(REG_KEY_HIGH, '0);
                end else begin
                    write_key(REG_KEY_LOW, {$urandom, $urandom});
                    write_key(REG_KEY_HIGH, {$urandom, $urandom});
                end
                send_random(100);
            end
        end
    endtask

    initial begin
        build_sbox();
        expand_schedule();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        snd_pct = 31;
        rcv_pct = 58;
        test_reset_key();
        test_directed();
        test_key_change();
        test_back_pressure();
        test_random();
        drain();
        if (err_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
